// ----- design/byte_stuffing_frame_encoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the byte stuffing frame encoder
// Shared helpers that wrap concurrent assertions with clock and reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFING_FRAME_ENCODER_UNIT_MACROS_SVH
`define BYTE_STUFFING_FRAME_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BSFE_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define BSFE_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared types and constants of the byte stuffing frame encoder.
// ----------------------------------------------------------------------------
package bsfe_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_FLAG_BYTE   = 2'd0;
	localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd1;
	localparam logic [1:0] CFG_ESCAPE_MASK = 2'd2;

	// Reset values of the configuration registers
	localparam logic [7:0] FLAG_RESET   = 8'd126;
	localparam logic [7:0] ESCAPE_RESET = 8'd125;
	localparam logic [7:0] MASK_RESET   = 8'd32;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] flag_byte;
		logic [7:0] escape_byte;
		logic [7:0] escape_mask;
	} cfg_t;

	// One classified word as the back end needs it
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] parity;
		logic [7:0] address;
		logic [7:0] control;
		logic       first;
		logic       last;
		logic       esc_data;
		logic       esc_parity;
	} item_t;

	// Write side of the queue
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_wr_t;

	// Read side of the queue
	typedef struct packed {
		logic  empty;
		item_t head;
	} q_rd_t;

endpackage

// ----- design/bsfe_front.sv -----
// ----------------------------------------------------------------------------
// bsfe_front
// Accepts input words, keeps the running payload check and marks which
// bytes need escaping before pushing them into the queue.
// ----------------------------------------------------------------------------
module bsfe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  bsfe_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       payload_byte,
	input  logic             first_of_frame,
	input  logic             last_of_frame,
	input  logic [7:0]       address_byte,
	input  logic [7:0]       control_byte,
	input  logic             q_full,
	output bsfe_pkg::q_wr_t  q_wr
);
	import bsfe_pkg::*;

	logic [7:0] parity_q;
	logic [7:0] parity_new;
	logic       accept;

	// Stall while the queue has no room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Restart the check on a new frame, otherwise fold in the byte
	assign parity_new = first_of_frame ? payload_byte : (parity_q ^ payload_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= '0;
		end else if (accept) begin
			parity_q <= last_of_frame ? 8'd0 : parity_new;
		end
	end

	// Classify the word for the back end
	always_comb begin
		q_wr.valid           = accept;
		q_wr.item.data       = payload_byte;
		q_wr.item.parity     = parity_new;
		q_wr.item.address    = address_byte;
		q_wr.item.control    = control_byte;
		q_wr.item.first      = first_of_frame;
		q_wr.item.last       = last_of_frame;
		q_wr.item.esc_data   = (payload_byte == cfg.flag_byte) ||
		                       (payload_byte == cfg.escape_byte);
		q_wr.item.esc_parity = (parity_new == cfg.flag_byte) ||
		                       (parity_new == cfg.escape_byte);
	end

endmodule

// ----- design/bsfe_queue.sv -----
// ----------------------------------------------------------------------------
// bsfe_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module bsfe_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  bsfe_pkg::q_wr_t  q_wr,
	output logic             q_full,
	input  logic             pop,
	output bsfe_pkg::q_rd_t  q_rd
);
	import bsfe_pkg::*;

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;

	assign q_full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_rd.empty = (count_q == '0);
	assign q_rd.head  = entry_q[rd_ptr_q];
	assign push       = q_wr.valid && !q_full;
	assign do_pop     = pop && !q_rd.empty;

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= q_wr.item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/bsfe_back.sv -----
// ----------------------------------------------------------------------------
// bsfe_back
// Sequencer that walks the head word through header (when it opens a frame),
// stuffed payload byte, stuffed check and closing flag (when it ends a frame),
// one line byte per cycle into the output register unless out_stall holds it.
// ----------------------------------------------------------------------------
module bsfe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bsfe_pkg::cfg_t   cfg,
	input  bsfe_pkg::q_rd_t  q_rd,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       line_byte,
	output logic             end_of_run,
	output logic             end_of_frame
);
	import bsfe_pkg::*;

	localparam logic [3:0] PH_HFLAG    = 4'd0;
	localparam logic [3:0] PH_ADDR     = 4'd1;
	localparam logic [3:0] PH_CTRL     = 4'd2;
	localparam logic [3:0] PH_HCHK     = 4'd3;
	localparam logic [3:0] PH_DATA     = 4'd4;
	localparam logic [3:0] PH_DATA_ESC = 4'd5;
	localparam logic [3:0] PH_PAR      = 4'd6;
	localparam logic [3:0] PH_PAR_ESC  = 4'd7;
	localparam logic [3:0] PH_CFLAG    = 4'd8;

	logic [3:0] phase_q;
	logic       active_q;
	logic [3:0] phase_cur;
	logic [3:0] phase_nxt;
	logic [7:0] byte_cur;
	logic       done_cur;
	logic       eof_cur;
	logic       load;
	logic       out_valid_q;
	logic [7:0] line_byte_q;
	logic       end_of_run_q;
	logic       end_of_frame_q;
	item_t      hd;

	assign hd = q_rd.head;

	// Fresh word starts at the header or straight at the payload byte
	assign phase_cur = active_q ? phase_q : (hd.first ? PH_HFLAG : PH_DATA);

	// A word waits and the output register is free or being emptied this cycle
	assign load = !q_rd.empty && (!out_valid_q || !out_stall);
	assign pop  = load && done_cur;

	// Select the byte of the current phase and the phase after it
	always_comb begin
		byte_cur  = cfg.flag_byte;
		phase_nxt = PH_HFLAG;
		done_cur  = 1'b0;
		eof_cur   = 1'b0;
		unique case (phase_cur)
			PH_HFLAG: begin
				byte_cur  = cfg.flag_byte;
				phase_nxt = PH_ADDR;
			end
			PH_ADDR: begin
				byte_cur  = hd.address;
				phase_nxt = PH_CTRL;
			end
			PH_CTRL: begin
				byte_cur  = hd.control;
				phase_nxt = PH_HCHK;
			end
			PH_HCHK: begin
				byte_cur  = hd.address ^ hd.control;
				phase_nxt = PH_DATA;
			end
			PH_DATA: begin
				if (hd.esc_data) begin
					byte_cur  = cfg.escape_byte;
					phase_nxt = PH_DATA_ESC;
				end else begin
					byte_cur  = hd.data;
					phase_nxt = PH_PAR;
					done_cur  = !hd.last;
				end
			end
			PH_DATA_ESC: begin
				byte_cur  = hd.data ^ cfg.escape_mask;
				phase_nxt = PH_PAR;
				done_cur  = !hd.last;
			end
			PH_PAR: begin
				if (hd.esc_parity) begin
					byte_cur  = cfg.escape_byte;
					phase_nxt = PH_PAR_ESC;
				end else begin
					byte_cur  = hd.parity;
					phase_nxt = PH_CFLAG;
				end
			end
			PH_PAR_ESC: begin
				byte_cur  = hd.parity ^ cfg.escape_mask;
				phase_nxt = PH_CFLAG;
			end
			PH_CFLAG: begin
				byte_cur = cfg.flag_byte;
				done_cur = 1'b1;
				eof_cur  = 1'b1;
			end
			default: begin
				done_cur = 1'b1;
			end
		endcase
	end

	// Advance the sequencer and go idle once the word's last byte is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HFLAG;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q <= !done_cur;
				phase_q  <= phase_nxt;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the output word while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			line_byte_q    <= byte_cur;
			end_of_run_q   <= done_cur;
			end_of_frame_q <= eof_cur;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_byte    = line_byte_q;
	assign end_of_run   = end_of_run_q;
	assign end_of_frame = end_of_frame_q;

endmodule

// ----- design/byte_stuffing_frame_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// byte_stuffing_frame_encoder_unit
// HDLC-style framer: header, byte-stuffed payload and check, closing flag.
// ----------------------------------------------------------------------------
// Accepts one payload word per cycle, unless in_stall is raised, into a
// four-entry queue and sends one line byte per cycle from a registered output
// while out_stall is low. A word yields four header bytes when it opens a
// frame, one or two for the stuffed payload byte, and one or two for the
// stuffed check plus the closing flag when it ends a frame. The sustained rate
// is set by the back-end sequencer, which loads the first byte of a word from
// the head of the queue into the output register. Frame check and escape
// decisions use the configuration as it stands when a word is taken,
// so registers should only be written while nothing is in flight.
// ----------------------------------------------------------------------------
`include "byte_stuffing_frame_encoder_unit_macros.svh"

module byte_stuffing_frame_encoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] payload_byte,
	input  logic       first_of_frame,
	input  logic       last_of_frame,
	input  logic [7:0] address_byte,
	input  logic [7:0] control_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] line_byte,
	output logic       end_of_run,
	output logic       end_of_frame
);
	import bsfe_pkg::*;

	cfg_t  cfg_q;
	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte   <= FLAG_RESET;
			cfg_q.escape_byte <= ESCAPE_RESET;
			cfg_q.escape_mask <= MASK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FLAG_BYTE:   cfg_q.flag_byte   <= cfg_data;
				CFG_ESCAPE_BYTE: cfg_q.escape_byte <= cfg_data;
				CFG_ESCAPE_MASK: cfg_q.escape_mask <= cfg_data;
				default: ;
			endcase
		end
	end

	bsfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.payload_byte   (payload_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.address_byte   (address_byte),
		.control_byte   (control_byte),
		.q_full         (q_full),
		.q_wr           (q_wr)
	);

	bsfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.pop    (pop),
		.q_rd   (q_rd)
	);

	bsfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_rd         (q_rd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_byte    (line_byte),
		.end_of_run   (end_of_run),
		.end_of_frame (end_of_frame)
	);

	// Closing flag ends the run of its word
	`BSFE_ASSERT_IMP(a_eof_ends_run, clk, arst_n, out_valid && end_of_frame, end_of_run, "closing flag without end of run")

	// Closing flag carries the configured flag value
	`BSFE_ASSERT_IMP(a_eof_is_flag, clk, arst_n, out_valid && end_of_frame, line_byte == cfg_q.flag_byte, "closing flag byte mismatch")

	// A frame needs at least payload and check before the next closing flag
	`BSFE_ASSERT_NXT(a_no_double_eof, clk, arst_n, out_valid && end_of_frame && !out_stall, !(out_valid && end_of_frame), "closing flags back to back")

endmodule
